/* rtl/als_pkg.sv */
// Package for the array list store: capacity, widths, operation and status
// codes, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package als_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic [AW-1:0]      addr_t;
  typedef logic [CW-1:0]      cnt_t;
  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_ERASE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

/* rtl/array_list_store.sv */
// Array list store: a packed list of signed words held in a memory with one
// read and one write port, with a small sequencer that scans and shifts one
// entry a cycle. Depends on als_pkg.
//
// The block takes one request at a time and answers each with one result.
// An append goes from idle straight to the response state; a read passes
// through the read state first. A find reads the stored entries one per
// cycle through the single memory read port and compares each against the
// requested word. An erase scans the same way up to the first match and
// then moves every later entry down one place, again one entry a cycle
// through the same read port. The entries are not cleared at reset; only
// the fill count is, and no entry at or above it ever reaches a comparison
// or a result. A new request is taken while the previous result still
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module array_list_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [1:0]          kind,
  input  wire als_pkg::word_t      value,
  input  wire logic [3:0]          index,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      als_pkg::word_t      data,
  output      logic                hit,
  output      logic [3:0]          position,
  output      logic [4:0]          count,
  output      logic [1:0]          status
);

  import als_pkg::*;

  localparam cnt_t DEPTH_C = CW'(DEPTH);

  state_t  state, state_next;
  kind_t   kind_q, kind_q_next;
  word_t   value_q, value_q_next;
  cnt_t    fill_count, fill_count_next;
  cnt_t    ptr, ptr_next;
  logic    cmp_valid, cmp_valid_next;
  addr_t   cmp_addr, cmp_addr_next;

  word_t   res_data, res_data_next;
  logic    res_hit, res_hit_next;
  addr_t   res_pos, res_pos_next;
  status_t res_status, res_status_next;

  logic          out_valid_next;
  word_t         data_next;
  logic          hit_next;
  logic [3:0]    position_next;
  logic [4:0]    count_next;
  logic [1:0]    status_next;

  word_t mem [DEPTH];
  word_t rdata;
  logic  mem_we;
  addr_t mem_waddr;
  word_t mem_wdata;
  addr_t mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next      = state;
    kind_q_next     = kind_q;
    value_q_next    = value_q;
    fill_count_next = fill_count;
    ptr_next        = ptr;
    cmp_valid_next  = 1'b0;
    cmp_addr_next   = cmp_addr;
    res_data_next   = res_data;
    res_hit_next    = res_hit;
    res_pos_next    = res_pos;
    res_status_next = res_status;
    out_valid_next  = out_valid && !out_ready;
    data_next       = data;
    hit_next        = hit;
    position_next   = position;
    count_next      = count;
    status_next     = status;
    mem_we          = 1'b0;
    mem_waddr       = fill_count[AW-1:0];
    mem_wdata       = value_q;
    mem_raddr       = ptr[AW-1:0];
    in_ready        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_raddr = index;
        if (in_valid) begin
          kind_q_next     = kind_t'(kind);
          value_q_next    = value;
          res_data_next   = '0;
          res_hit_next    = 1'b0;
          res_pos_next    = '0;
          res_status_next = STAT_OK;
          ptr_next        = '0;
          unique case (kind_t'(kind))
            KIND_APPEND: begin
              if (fill_count >= DEPTH_C) begin
                res_status_next = STAT_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_wdata       = value;
                fill_count_next = fill_count + 1'b1;
              end
              state_next = ST_RESP;
            end
            KIND_READ: begin
              if ({1'b0, index} < fill_count) begin
                state_next = ST_READ;
              end else begin
                res_status_next = STAT_RANGE;
                state_next      = ST_RESP;
              end
            end
            KIND_FIND, KIND_ERASE: begin
              state_next = ST_SCAN;
            end
          endcase
        end
      end

      ST_READ: begin
        res_data_next = rdata;
        state_next    = ST_RESP;
      end

      // The read issued in one cycle is compared in the next, so the scan
      // keeps one entry in flight behind the pointer.
      ST_SCAN: begin
        if (cmp_valid && rdata == value_q) begin
          res_hit_next = 1'b1;
          res_pos_next = cmp_addr;
          if (kind_q == KIND_ERASE) begin
            ptr_next   = {1'b0, cmp_addr} + 1'b1;
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_RESP;
          end
        end else if (ptr < fill_count) begin
          cmp_valid_next = 1'b1;
          cmp_addr_next  = ptr[AW-1:0];
          ptr_next       = ptr + 1'b1;
        end else if (!cmp_valid) begin
          res_status_next = STAT_NOTFOUND;
          state_next      = ST_RESP;
        end
      end

      // Each entry read here is written back one place lower in the next cycle.
      ST_SHIFT: begin
        if (cmp_valid) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_addr - 1'b1;
          mem_wdata = rdata;
        end
        if (ptr < fill_count) begin
          cmp_valid_next = 1'b1;
          cmp_addr_next  = ptr[AW-1:0];
          ptr_next       = ptr + 1'b1;
        end else if (!cmp_valid) begin
          fill_count_next = fill_count - 1'b1;
          state_next      = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          data_next      = res_data;
          hit_next       = res_hit;
          position_next  = res_pos;
          count_next     = fill_count;
          status_next    = res_status;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      cmp_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      cmp_valid  <= cmp_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q     <= kind_q_next;
    value_q    <= value_q_next;
    ptr        <= ptr_next;
    cmp_addr   <= cmp_addr_next;
    res_data   <= res_data_next;
    res_hit    <= res_hit_next;
    res_pos    <= res_pos_next;
    res_status <= res_status_next;
    data       <= data_next;
    hit        <= hit_next;
    position   <= position_next;
    count      <= count_next;
    status     <= status_next;
  end

  assert property (@(posedge clk) disable iff (rst) fill_count <= DEPTH_C)
    else $error("fill count exceeds capacity");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_APPEND && fill_count < DEPTH_C)
    |=> fill_count == $past(fill_count) + 1'b1)
    else $error("append did not grow the list");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && state_next == ST_RESP)
    |=> fill_count == $past(fill_count) - 1'b1)
    else $error("erase did not shrink the list");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (status == STAT_OK && position <= count))
    else $error("hit reported with inconsistent status or position");

endmodule

`default_nettype wire

/* sim/array_list_store_test.sv */
// Self-checking testbench for array_list_store: drives append, read, find
// and erase requests and checks every result against an in-bench predictor.
// Depends on als_pkg and the array_list_store RTL.
`timescale 1ns / 1ps

module array_list_store_test;
  import als_pkg::*;

  localparam int NUM_RANDOM   = 523;
  localparam int PHASE_LEN    = 110;
  localparam int HOLD_AT      = 470;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    kind_t      op;
    word_t      word;
    logic [3:0] idx;
  } request_t;

  typedef struct {
    word_t      data;
    logic       hit;
    logic [3:0] position;
    logic [4:0] count;
    status_t    status;
  } outcome_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] kind      = '0;
  word_t      value     = '0;
  logic [3:0] index     = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  word_t      data;
  logic       hit;
  logic [3:0] position;
  logic [4:0] count;
  logic [1:0] status;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  word_t    planned_words[$];

  // Predicted contents of the list, advanced as each request is accepted.
  word_t list_words[DEPTH];
  int    list_len = 0;

  int  sent          = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  req_accepted  = 1'b0;
  int  cycles        = 0;
  int  fails         = 0;
  int  checked       = 0;
  int  kind_seen[4]  = '{0, 0, 0, 0};
  int  status_seen[4] = '{0, 0, 0, 0};
  int  hits_seen     = 0;

  array_list_store u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .hit       (hit),
    .position  (position),
    .count     (count),
    .status    (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int sender_idle_pct(int n);
    case ((n / PHASE_LEN) % 5)
      1: return 84;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int n);
    case ((n / PHASE_LEN) % 5)
      2: return 84;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic outcome_t apply_list_op(request_t r);
    outcome_t o;
    int       first;
    o.data     = '0;
    o.hit      = 1'b0;
    o.position = '0;
    o.status   = STAT_OK;
    case (r.op)
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          list_words[list_len] = r.word;
          list_len++;
        end
      end
      KIND_READ: begin
        if (int'(r.idx) < list_len) o.data = list_words[r.idx];
        else o.status = STAT_RANGE;
      end
      default: begin
        first = list_len;
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == r.word) first = i;
        end
        if (first < list_len) begin
          o.hit      = 1'b1;
          o.position = first[3:0];
          if (r.op == KIND_ERASE) begin
            for (int j = first; j + 1 < list_len; j++) list_words[j] = list_words[j + 1];
            list_len--;
          end
        end else begin
          o.status = STAT_NOTFOUND;
        end
      end
    endcase
    o.count = list_len[4:0];
    return o;
  endfunction

  // Queues a request and keeps a rough picture of the list, so that later
  // finds and erases can aim at words that are really stored.
  task automatic queue_request(kind_t op, word_t word, logic [3:0] idx);
    request_t r;
    r.op   = op;
    r.word = word;
    r.idx  = idx;
    pending_requests.push_back(r);
    if (op == KIND_APPEND && planned_words.size() < DEPTH) begin
      planned_words.push_back(word);
    end else if (op == KIND_ERASE) begin
      for (int i = 0; i < planned_words.size(); i++) begin
        if (planned_words[i] == word) begin
          planned_words.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 50 && planned_words.size() > 0)
      return planned_words[$urandom_range(planned_words.size() - 1)];
    if (r < 75) return word_t'($urandom_range(7)) - 4;
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return word_t'($urandom());
  endfunction

  function automatic logic [3:0] pick_index();
    if ($urandom_range(99) < 70 && planned_words.size() > 0)
      return 4'($urandom_range(planned_words.size() - 1));
    return 4'($urandom_range(15));
  endfunction

  // Sender: a new request is offered only once the previous one has gone.
  always @(negedge clk) begin
    request_t r;
    if (!rst && (!in_valid || req_accepted)) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct(sent)) begin
        r = pending_requests.pop_front();
        kind     <= r.op;
        value    <= r.word;
        index    <= r.idx;
        in_valid <= 1'b1;
        sent     <= sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct(sent));
    end
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    request_t r;
    bit       bad;
    req_accepted <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding: data %0d count %0d", data, count);
        fails++;
      end else begin
        exp_o = expected_outcomes.pop_front();
        bad   = 1'b0;
        if (data !== exp_o.data) begin
          $error("data: expected %0d, got %0d", exp_o.data, data);
          bad = 1'b1;
        end
        if (hit !== exp_o.hit) begin
          $error("hit: expected %0d, got %0d", exp_o.hit, hit);
          bad = 1'b1;
        end
        if (position !== exp_o.position) begin
          $error("position: expected %0d, got %0d", exp_o.position, position);
          bad = 1'b1;
        end
        if (count !== exp_o.count) begin
          $error("count: expected %0d, got %0d", exp_o.count, count);
          bad = 1'b1;
        end
        if (status !== exp_o.status) begin
          $error("status: expected %0d, got %0d", exp_o.status, status);
          bad = 1'b1;
        end
        if (bad) fails++;
        checked++;
        status_seen[exp_o.status]++;
        if (exp_o.hit) hits_seen++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      r.op   = kind_t'(kind);
      r.word = value;
      r.idx  = index;
      kind_seen[kind]++;
      expected_outcomes.push_back(apply_list_op(r));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycles, expected_outcomes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    word_t  edge_words[7];
    kind_t  op;
    bit     grow;
    int     r;
    edge_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h5, 32'h5};

    // Empty list: reads out of range, find and erase miss.
    queue_request(KIND_READ, 32'h0, 4'd15);
    queue_request(KIND_READ, 32'h0, 4'd0);
    queue_request(KIND_FIND, 32'h0, 4'd0);
    queue_request(KIND_ERASE, 32'hffff_ffff, 4'd0);
    // Fill to capacity with the extremes and a duplicate, then overfill.
    foreach (edge_words[i]) queue_request(KIND_APPEND, edge_words[i], 4'd0);
    for (int i = 0; i < 9; i++) queue_request(KIND_APPEND, word_t'($urandom()), 4'd0);
    queue_request(KIND_APPEND, 32'h7fff_ffff, 4'd0);
    queue_request(KIND_READ, 32'h0, 4'd15);
    // The duplicate must be found at its first position only.
    queue_request(KIND_FIND, 32'h5, 4'd0);
    queue_request(KIND_ERASE, 32'h5, 4'd0);
    queue_request(KIND_ERASE, planned_words[planned_words.size() - 1], 4'd0);
    queue_request(KIND_READ, 32'h0, 4'(planned_words.size()));
    queue_request(KIND_ERASE, 32'h8000_0000, 4'd0);
    queue_request(KIND_READ, 32'h0, 4'd0);

    // Random part alternates between growing and shrinking the list so that
    // both the empty and the full ends are visited repeatedly.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      grow = ((n / 40) % 2) == 0;
      r    = $urandom_range(99);
      if (grow) op = r < 50 ? KIND_APPEND : r < 70 ? KIND_READ : r < 85 ? KIND_FIND : KIND_ERASE;
      else      op = r < 15 ? KIND_APPEND : r < 35 ? KIND_READ : r < 55 ? KIND_FIND : KIND_ERASE;
      queue_request(op, pick_word(), pick_index());
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_requests.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outcomes.size() > 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      fails++;
    end

    $display("%0d results checked: %0d appends, %0d reads, %0d finds, %0d erases",
             checked, kind_seen[KIND_APPEND], kind_seen[KIND_READ],
             kind_seen[KIND_FIND], kind_seen[KIND_ERASE]);
    $display("%0d hits, %0d refused as full, %0d out of range, %0d misses",
             hits_seen, status_seen[STAT_FULL], status_seen[STAT_RANGE],
             status_seen[STAT_NOTFOUND]);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
